// ===== rtl/rrid_pkg.sv =====
// ----------------------------------------------------------------------------
// rrid_pkg
// Shared types, constants and fixed-point helpers of the RRR arm dynamics unit.
// ----------------------------------------------------------------------------
package rrid_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 4;

  localparam int Z_W  = 36;
  localparam int XY_W = 34;

  localparam logic signed [Z_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [Z_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [Z_W-1:0] PI3_Q30     = 36'sd10119778278;
  localparam logic signed [Z_W-1:0] PI4_Q30     = 36'sd13493037704;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic signed [Z_W-1:0] ATAN_Q30 [ATAN_LEN] = '{
    36'sd843314856, 36'sd497837829, 36'sd263043836, 36'sd133525158,
    36'sd67021686,  36'sd33543515,  36'sd16775850,  36'sd8388437,
    36'sd4194282,   36'sd2097149,   36'sd1048575,   36'sd524287,
    36'sd262143,    36'sd131071,    36'sd65535,     36'sd32767,
    36'sd16383,     36'sd8191,      36'sd4095,      36'sd2047,
    36'sd1023,      36'sd511,       36'sd255,       36'sd127
  };

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int SAT_IN_W = 52;

  typedef enum logic [2:0] {
    REG_INERTIA_BASE   = 3'd0,
    REG_LINK2_COS_GAIN = 3'd1,
    REG_LINK3_COS_GAIN = 3'd2,
    REG_COUPLING_GAIN  = 3'd3,
    REG_SHOULDER_CONST = 3'd4,
    REG_ELBOW_CONST    = 3'd5,
    REG_GRAVITY_LINK2  = 3'd6,
    REG_GRAVITY_LINK3  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] inertia_base;
    logic signed [31:0] link2_cos_gain;
    logic signed [31:0] link3_cos_gain;
    logic signed [31:0] coupling_gain;
    logic signed [31:0] shoulder_inertia_const;
    logic signed [31:0] elbow_inertia_const;
    logic signed [31:0] gravity_link2;
    logic signed [31:0] gravity_link3;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] v0;
    logic signed [15:0] v1;
    logic signed [15:0] v2;
    logic signed [15:0] a0;
    logic signed [15:0] a1;
    logic signed [15:0] a2;
  } kin_t;

  typedef struct packed {
    logic signed [17:0] s2;
    logic signed [17:0] c2;
    logic signed [17:0] s3;
    logic signed [17:0] c3;
    logic signed [17:0] s23;
    logic signed [17:0] c23;
    kin_t               kin;
  } mid_t;

  typedef struct packed {
    logic signed [31:0] inertia_rate_0;
    logic signed [31:0] inertia_rate_1;
    logic signed [31:0] inertia_rate_2;
    logic signed [31:0] accel_coriolis_0;
    logic signed [31:0] accel_coriolis_1;
    logic signed [31:0] accel_coriolis_2;
    logic signed [31:0] gravity_load_1;
    logic signed [31:0] gravity_load_2;
    logic               saturated;
  } res_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } sat_t;

  function automatic logic signed [19:0] mul_trig(input logic signed [17:0] a,
                                                   input logic signed [17:0] b);
    logic signed [35:0] p;
    p = a * b;
    p = p + 36'sd32768;
    return p[35:16];
  endfunction

  function automatic logic signed [36:0] mul_rnd16(input logic signed [31:0] a,
                                                    input logic signed [20:0] b);
    logic signed [52:0] p;
    p = a * b;
    p = p + 53'sd32768;
    return p[52:16];
  endfunction

  function automatic logic signed [39:0] mul_rnd8(input logic signed [31:0] a,
                                                   input logic signed [15:0] b);
    logic signed [47:0] p;
    p = a * b;
    p = p + 48'sd128;
    return p[47:8];
  endfunction

  function automatic logic signed [47:0] mul_w16(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    p = p + 64'sd32768;
    return p[63:16];
  endfunction

  function automatic sat_t sat32(input logic signed [SAT_IN_W-1:0] x);
    sat_t r;
    if (x > 52'sd2147483647) begin
      r.clip = 1'b1;
      r.val  = 32'sh7fffffff;
    end else if (x < -52'sd2147483648) begin
      r.clip = 1'b1;
      r.val  = 32'sh80000000;
    end else begin
      r.clip = 1'b0;
      r.val  = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/rrid_cordic.sv =====
// ----------------------------------------------------------------------------
// rrid_cordic
// Pipelined sine/cosine: 4pi and 2pi wrap, quadrant fold, one CORDIC step per stage.
// ----------------------------------------------------------------------------
module rrid_cordic import rrid_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [16:0] ang,
  output logic signed [17:0] sin_o,
  output logic signed [17:0] cos_o
);

  logic signed [Z_W-1:0]  z_in;
  logic signed [Z_W-1:0]  wrap4_nxt, wrap4_r;
  logic signed [Z_W-1:0]  wrap2_nxt, wrap2_r;
  logic signed [Z_W-1:0]  fold_nxt;
  logic                   fold_neg_nxt;
  logic signed [Z_W-1:0]  z_r   [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] x_r   [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] y_r   [CORDIC_STEPS+1];
  logic                   neg_r [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] x_fin, x_rnd, y_rnd;
  logic signed [17:0]     sin_r, cos_r;

  always_comb begin
    z_in = {{(Z_W-35){ang[16]}}, ang, 18'd0};
    if (z_in > PI3_Q30) begin
      wrap4_nxt = z_in - PI4_Q30;
    end else if (z_in < -PI3_Q30) begin
      wrap4_nxt = z_in + PI4_Q30;
    end else begin
      wrap4_nxt = z_in;
    end
    if (wrap4_r > PI_Q30) begin
      wrap2_nxt = wrap4_r - TWO_PI_Q30;
    end else if (wrap4_r < -PI_Q30) begin
      wrap2_nxt = wrap4_r + TWO_PI_Q30;
    end else begin
      wrap2_nxt = wrap4_r;
    end
    if (wrap2_r > HALF_PI_Q30) begin
      fold_nxt     = PI_Q30 - wrap2_r;
      fold_neg_nxt = 1'b1;
    end else if (wrap2_r < -HALF_PI_Q30) begin
      fold_nxt     = -PI_Q30 - wrap2_r;
      fold_neg_nxt = 1'b1;
    end else begin
      fold_nxt     = wrap2_r;
      fold_neg_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wrap4_r  <= wrap4_nxt;
      wrap2_r  <= wrap2_nxt;
      z_r[0]   <= fold_nxt;
      neg_r[0] <= fold_neg_nxt;
      x_r[0]   <= CORDIC_GAIN_Q30;
      y_r[0]   <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN_Q30[i];
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN_Q30[i];
        end
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  always_comb begin
    x_fin = neg_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
    x_rnd = x_fin + 34'sd8192;
    y_rnd = y_r[CORDIC_STEPS] + 34'sd8192;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= y_rnd[31:14];
      cos_r <= x_rnd[31:14];
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

// ===== rtl/rrid_front.sv =====
// ----------------------------------------------------------------------------
// rrid_front
// Accepts items, runs the three angle CORDICs and hands items to the queue.
// ----------------------------------------------------------------------------
module rrid_front import rrid_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] angle_shoulder,
  input  logic signed [15:0] angle_elbow,
  input  kin_t               kin,
  output logic               q_push,
  output mid_t               q_data,
  input  logic               q_full
);

  logic                    en;
  logic [CORDIC_LAT-1:0]   v_r;
  kin_t                    kin_r [CORDIC_LAT];
  logic signed [16:0]      ang2, ang3, ang23;
  logic signed [17:0]      s2, c2, s3, c3, s23, c23;

  assign en     = !v_r[CORDIC_LAT-1] || !q_full;
  assign full   = !en;
  assign q_push = v_r[CORDIC_LAT-1] && !q_full;

  assign ang2  = {angle_shoulder[15], angle_shoulder};
  assign ang3  = {angle_elbow[15], angle_elbow};
  assign ang23 = ang2 + ang3;

  rrid_cordic u_cordic_2  (.clk(clk), .en(en), .ang(ang2),  .sin_o(s2),  .cos_o(c2));
  rrid_cordic u_cordic_3  (.clk(clk), .en(en), .ang(ang3),  .sin_o(s3),  .cos_o(c3));
  rrid_cordic u_cordic_23 (.clk(clk), .en(en), .ang(ang23), .sin_o(s23), .cos_o(c23));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[CORDIC_LAT-2:0], push};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kin_r[0] <= kin;
      for (int i = 1; i < CORDIC_LAT; i++) begin
        kin_r[i] <= kin_r[i-1];
      end
    end
  end

  always_comb begin
    q_data.s2  = s2;
    q_data.c2  = c2;
    q_data.s3  = s3;
    q_data.c3  = c3;
    q_data.s23 = s23;
    q_data.c23 = c23;
    q_data.kin = kin_r[CORDIC_LAT-1];
  end

endmodule

// ===== rtl/rrid_queue.sv =====
// ----------------------------------------------------------------------------
// rrid_queue
// Short queue between the trig front end and the dynamics back end.
// ----------------------------------------------------------------------------
module rrid_queue import rrid_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  mid_t wdata,
  output logic full,
  input  logic pop,
  output mid_t rdata,
  output logic empty
);

  mid_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_r, rptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + Q_CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - Q_CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + Q_PTR_W'(1);
      if (pop)  rptr_r <= rptr_r + Q_PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/rrid_back.sv =====
// ----------------------------------------------------------------------------
// rrid_back
// Dynamics datapath: trig products, lumped-constant products, inertia and
// Coriolis terms, saturation, and the result queue.
// ----------------------------------------------------------------------------
module rrid_back import rrid_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic q_empty,
  input  mid_t q_data,
  output logic q_pop,
  output logic out_empty,
  input  logic out_pop,
  output res_t res
);

  typedef struct packed {
    logic signed [19:0] c2c2, c23c23, c2c23, c2s2, c23s23, c2s23, c23s2;
    logic signed [17:0] c2, c23, s3, c3;
    logic signed [31:0] w00, w01, w02, w11, w12, w22;
    kin_t               kin;
  } s1_t;

  typedef struct packed {
    logic signed [36:0] ta, tb, tk, tk3, pa, pb, pk, qk, rk, g2, g3;
    logic signed [31:0] w00, w01, w02, w11, w12, w22;
    kin_t               kin;
  } s2_t;

  typedef struct packed {
    logic signed [31:0] m00, m11, m12, pp, qq, rr, gr1, gr2;
    logic               clip;
    logic signed [31:0] w00, w01, w02, w11, w12, w22;
    kin_t               kin;
  } s3_t;

  typedef struct packed {
    logic signed [39:0] r0, r1a, r1b, r2a, r2b, c0a, c1a, c1b, c2a, c2b;
    logic signed [47:0] p01, q02, p00, r12, r22, q00, r11;
    logic signed [31:0] gr1, gr2;
    logic               clip;
  } s4_t;

  logic               en;
  logic [3:0]         v_r;
  s1_t                s1_r, s1_nxt;
  s2_t                s2_r, s2_nxt;
  s3_t                s3_r, s3_nxt;
  s4_t                s4_r, s4_nxt;
  res_t               res_nxt;
  logic signed [20:0] cs_sum;
  logic signed [SAT_IN_W-1:0] sum_m00, sum_m11, sum_m12, sum_p, sum_q, sum_r;
  logic signed [SAT_IN_W-1:0] sum_g1, sum_g2;
  logic signed [SAT_IN_W-1:0] sum_r0, sum_r1, sum_r2, sum_c0, sum_c1, sum_c2;
  sat_t sm00, sm11, sm12, sp, sq, sr, sg1, sg2;
  sat_t so_r0, so_r1, so_r2, so_c0, so_c1, so_c2;

  res_t               oq_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] owptr_r, orptr_r;
  logic [Q_CNT_W-1:0] ocnt_r, ocnt_nxt;
  logic               oq_full, oq_push;

  assign oq_full = (ocnt_r == Q_CNT_W'(Q_DEPTH));
  assign en      = !v_r[3] || !oq_full;
  assign q_pop   = en && !q_empty;
  assign oq_push = en && v_r[3];

  always_comb begin
    s1_nxt.c2c2   = mul_trig(q_data.c2, q_data.c2);
    s1_nxt.c23c23 = mul_trig(q_data.c23, q_data.c23);
    s1_nxt.c2c23  = mul_trig(q_data.c2, q_data.c23);
    s1_nxt.c2s2   = mul_trig(q_data.c2, q_data.s2);
    s1_nxt.c23s23 = mul_trig(q_data.c23, q_data.s23);
    s1_nxt.c2s23  = mul_trig(q_data.c2, q_data.s23);
    s1_nxt.c23s2  = mul_trig(q_data.c23, q_data.s2);
    s1_nxt.c2     = q_data.c2;
    s1_nxt.c23    = q_data.c23;
    s1_nxt.s3     = q_data.s3;
    s1_nxt.c3     = q_data.c3;
    s1_nxt.w00    = q_data.kin.v0 * q_data.kin.v0;
    s1_nxt.w01    = q_data.kin.v0 * q_data.kin.v1;
    s1_nxt.w02    = q_data.kin.v0 * q_data.kin.v2;
    s1_nxt.w11    = q_data.kin.v1 * q_data.kin.v1;
    s1_nxt.w12    = q_data.kin.v1 * q_data.kin.v2;
    s1_nxt.w22    = q_data.kin.v2 * q_data.kin.v2;
    s1_nxt.kin    = q_data.kin;
  end

  always_comb begin
    cs_sum     = s1_r.c2s23 + s1_r.c23s2;
    s2_nxt.ta  = mul_rnd16(cfg.link2_cos_gain, s1_r.c2c2);
    s2_nxt.tb  = mul_rnd16(cfg.link3_cos_gain, s1_r.c23c23);
    s2_nxt.tk  = mul_rnd16(cfg.coupling_gain, s1_r.c2c23);
    s2_nxt.tk3 = mul_rnd16(cfg.coupling_gain, s1_r.c3);
    s2_nxt.pa  = mul_rnd16(cfg.link2_cos_gain, s1_r.c2s2);
    s2_nxt.pb  = mul_rnd16(cfg.link3_cos_gain, s1_r.c23s23);
    s2_nxt.pk  = mul_rnd16(cfg.coupling_gain, cs_sum);
    s2_nxt.qk  = mul_rnd16(cfg.coupling_gain, s1_r.c2s23);
    s2_nxt.rk  = mul_rnd16(cfg.coupling_gain, s1_r.s3);
    s2_nxt.g2  = mul_rnd16(cfg.gravity_link2, s1_r.c2);
    s2_nxt.g3  = mul_rnd16(cfg.gravity_link3, s1_r.c23);
    s2_nxt.w00 = s1_r.w00;
    s2_nxt.w01 = s1_r.w01;
    s2_nxt.w02 = s1_r.w02;
    s2_nxt.w11 = s1_r.w11;
    s2_nxt.w12 = s1_r.w12;
    s2_nxt.w22 = s1_r.w22;
    s2_nxt.kin = s1_r.kin;
  end

  always_comb begin
    sum_m00 = cfg.inertia_base + s2_r.ta + s2_r.tb + 2 * s2_r.tk;
    sum_m11 = cfg.shoulder_inertia_const + 2 * s2_r.tk3;
    sum_m12 = cfg.elbow_inertia_const + s2_r.tk3;
    sum_p   = -(s2_r.pa + s2_r.pb + s2_r.pk);
    sum_q   = -(s2_r.pb + s2_r.qk);
    sum_r   = s2_r.rk;
    sum_g1  = -(s2_r.g2 + s2_r.g3);
    sum_g2  = -s2_r.g3;
    sm00 = sat32(sum_m00);
    sm11 = sat32(sum_m11);
    sm12 = sat32(sum_m12);
    sp   = sat32(sum_p);
    sq   = sat32(sum_q);
    sr   = sat32(sum_r);
    sg1  = sat32(sum_g1);
    sg2  = sat32(sum_g2);
    s3_nxt.m00  = sm00.val;
    s3_nxt.m11  = sm11.val;
    s3_nxt.m12  = sm12.val;
    s3_nxt.pp   = sp.val;
    s3_nxt.qq   = sq.val;
    s3_nxt.rr   = sr.val;
    s3_nxt.gr1  = sg1.val;
    s3_nxt.gr2  = sg2.val;
    s3_nxt.clip = sm00.clip | sm11.clip | sm12.clip | sp.clip | sq.clip | sr.clip |
                  sg1.clip | sg2.clip;
    s3_nxt.w00  = s2_r.w00;
    s3_nxt.w01  = s2_r.w01;
    s3_nxt.w02  = s2_r.w02;
    s3_nxt.w11  = s2_r.w11;
    s3_nxt.w12  = s2_r.w12;
    s3_nxt.w22  = s2_r.w22;
    s3_nxt.kin  = s2_r.kin;
  end

  always_comb begin
    s4_nxt.r0   = mul_rnd8(s3_r.m00, s3_r.kin.v0);
    s4_nxt.r1a  = mul_rnd8(s3_r.m11, s3_r.kin.v1);
    s4_nxt.r1b  = mul_rnd8(s3_r.m12, s3_r.kin.v2);
    s4_nxt.r2a  = mul_rnd8(s3_r.m12, s3_r.kin.v1);
    s4_nxt.r2b  = mul_rnd8(cfg.elbow_inertia_const, s3_r.kin.v2);
    s4_nxt.c0a  = mul_rnd8(s3_r.m00, s3_r.kin.a0);
    s4_nxt.c1a  = mul_rnd8(s3_r.m11, s3_r.kin.a1);
    s4_nxt.c1b  = mul_rnd8(s3_r.m12, s3_r.kin.a2);
    s4_nxt.c2a  = mul_rnd8(s3_r.m12, s3_r.kin.a1);
    s4_nxt.c2b  = mul_rnd8(cfg.elbow_inertia_const, s3_r.kin.a2);
    s4_nxt.p01  = mul_w16(s3_r.pp, s3_r.w01);
    s4_nxt.q02  = mul_w16(s3_r.qq, s3_r.w02);
    s4_nxt.p00  = mul_w16(s3_r.pp, s3_r.w00);
    s4_nxt.r12  = mul_w16(s3_r.rr, s3_r.w12);
    s4_nxt.r22  = mul_w16(s3_r.rr, s3_r.w22);
    s4_nxt.q00  = mul_w16(s3_r.qq, s3_r.w00);
    s4_nxt.r11  = mul_w16(s3_r.rr, s3_r.w11);
    s4_nxt.gr1  = s3_r.gr1;
    s4_nxt.gr2  = s3_r.gr2;
    s4_nxt.clip = s3_r.clip;
  end

  always_comb begin
    sum_r0 = s4_r.r0;
    sum_r1 = s4_r.r1a + s4_r.r1b;
    sum_r2 = s4_r.r2a + s4_r.r2b;
    sum_c0 = s4_r.c0a + 2 * s4_r.p01 + 2 * s4_r.q02;
    sum_c1 = s4_r.c1a + s4_r.c1b - s4_r.p00 - 2 * s4_r.r12 - s4_r.r22;
    sum_c2 = s4_r.c2a + s4_r.c2b - s4_r.q00 + s4_r.r11;
    so_r0 = sat32(sum_r0);
    so_r1 = sat32(sum_r1);
    so_r2 = sat32(sum_r2);
    so_c0 = sat32(sum_c0);
    so_c1 = sat32(sum_c1);
    so_c2 = sat32(sum_c2);
    res_nxt.inertia_rate_0   = so_r0.val;
    res_nxt.inertia_rate_1   = so_r1.val;
    res_nxt.inertia_rate_2   = so_r2.val;
    res_nxt.accel_coriolis_0 = so_c0.val;
    res_nxt.accel_coriolis_1 = so_c1.val;
    res_nxt.accel_coriolis_2 = so_c2.val;
    res_nxt.gravity_load_1   = s4_r.gr1;
    res_nxt.gravity_load_2   = s4_r.gr2;
    res_nxt.saturated        = s4_r.clip | so_r0.clip | so_r1.clip | so_r2.clip |
                               so_c0.clip | so_c1.clip | so_c2.clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
    end
  end

  always_comb begin
    unique case ({oq_push, out_pop && !out_empty})
      2'b10:   ocnt_nxt = ocnt_r + Q_CNT_W'(1);
      2'b01:   ocnt_nxt = ocnt_r - Q_CNT_W'(1);
      default: ocnt_nxt = ocnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owptr_r <= '0;
      orptr_r <= '0;
      ocnt_r  <= '0;
    end else begin
      if (oq_push)                owptr_r <= owptr_r + Q_PTR_W'(1);
      if (out_pop && !out_empty)  orptr_r <= orptr_r + Q_PTR_W'(1);
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[owptr_r] <= res_nxt;
    end
  end

  assign out_empty = (ocnt_r == '0);
  assign res       = oq_r[orptr_r];

endmodule

// ===== rtl/rrr_arm_inverse_dynamics.sv =====
// ----------------------------------------------------------------------------
// rrr_arm_inverse_dynamics
// Inverse-dynamics coefficient unit for a three-joint RRR arm. Items enter
// through a queue-style port (push/full) and results leave through one
// (empty/pop); one result per item, in order. The unit is fully pipelined and
// takes one item every clock while in_full is low. An item passes the trig
// front end (two wrap stages, 4pi then 2pi, a quadrant fold, 16 CORDIC steps,
// rounding), the 4-entry middle queue, the multiply/sum pipeline registers
// s1 to s4 and the 4-entry result queue. The 16-step CORDIC pipeline sets
// the latency. Registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module rrr_arm_inverse_dynamics import rrid_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [15:0] in_angle_base,
  input  logic signed [15:0] in_angle_shoulder,
  input  logic signed [15:0] in_angle_elbow,
  input  logic signed [15:0] in_rate_base,
  input  logic signed [15:0] in_rate_shoulder,
  input  logic signed [15:0] in_rate_elbow,
  input  logic signed [15:0] in_accel_base,
  input  logic signed [15:0] in_accel_shoulder,
  input  logic signed [15:0] in_accel_elbow,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_inertia_rate_0,
  output logic signed [31:0] out_inertia_rate_1,
  output logic signed [31:0] out_inertia_rate_2,
  output logic signed [31:0] out_accel_coriolis_0,
  output logic signed [31:0] out_accel_coriolis_1,
  output logic signed [31:0] out_accel_coriolis_2,
  output logic signed [31:0] out_gravity_load_1,
  output logic signed [31:0] out_gravity_load_2,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic signed [31:0] cfg_data
);

  cfg_t cfg_r;
  kin_t kin;
  mid_t fq_wdata, fq_rdata;
  logic fq_push, fq_full, fq_pop, fq_empty;
  res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_INERTIA_BASE:   cfg_r.inertia_base           <= cfg_data;
        REG_LINK2_COS_GAIN: cfg_r.link2_cos_gain         <= cfg_data;
        REG_LINK3_COS_GAIN: cfg_r.link3_cos_gain         <= cfg_data;
        REG_COUPLING_GAIN:  cfg_r.coupling_gain          <= cfg_data;
        REG_SHOULDER_CONST: cfg_r.shoulder_inertia_const <= cfg_data;
        REG_ELBOW_CONST:    cfg_r.elbow_inertia_const    <= cfg_data;
        REG_GRAVITY_LINK2:  cfg_r.gravity_link2          <= cfg_data;
        REG_GRAVITY_LINK3:  cfg_r.gravity_link3          <= cfg_data;
        default:            cfg_r <= cfg_r;
      endcase
    end
  end

  // joint 1 angle does not enter the dynamics
  always_comb begin
    kin.v0 = in_rate_base;
    kin.v1 = in_rate_shoulder;
    kin.v2 = in_rate_elbow;
    kin.a0 = in_accel_base;
    kin.a1 = in_accel_shoulder;
    kin.a2 = in_accel_elbow;
  end

  rrid_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (in_push),
    .full           (in_full),
    .angle_shoulder (in_angle_shoulder),
    .angle_elbow    (in_angle_elbow),
    .kin            (kin),
    .q_push         (fq_push),
    .q_data         (fq_wdata),
    .q_full         (fq_full)
  );

  rrid_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata (fq_rdata),
    .empty (fq_empty)
  );

  rrid_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (fq_empty),
    .q_data    (fq_rdata),
    .q_pop     (fq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .res       (res)
  );

  assign out_inertia_rate_0   = res.inertia_rate_0;
  assign out_inertia_rate_1   = res.inertia_rate_1;
  assign out_inertia_rate_2   = res.inertia_rate_2;
  assign out_accel_coriolis_0 = res.accel_coriolis_0;
  assign out_accel_coriolis_1 = res.accel_coriolis_1;
  assign out_accel_coriolis_2 = res.accel_coriolis_2;
  assign out_gravity_load_1   = res.gravity_load_1;
  assign out_gravity_load_2   = res.gravity_load_2;
  assign out_saturated        = res.saturated;

endmodule

// ===== tb/tb_rrr_arm_inverse_dynamics.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rrr_arm_inverse_dynamics
// Self-checking bench for the RRR arm dynamics unit. Items are pushed from a
// queue with random idle bursts, results are popped with random stalls (one
// long stall fills the pipeline), and every result is compared per field with
// an integer fixed-point prediction computed in the bench.
// ----------------------------------------------------------------------------
module tb_rrr_arm_inverse_dynamics;
  import rrid_pkg::*;

  localparam longint PI_Z      = 64'sd3373259426;
  localparam longint HALF_PI_Z = 64'sd1686629713;
  localparam longint TWO_PI_Z  = 64'sd6746518852;
  localparam longint GAIN_X    = 64'sd652032874;
  localparam int     N_STEPS   = 16;
  localparam int     LAT       = 40;
  localparam longint LIMIT     = 400000;

  typedef struct packed {
    logic signed [15:0] q1, q2, q3, v0, v1, v2, a0, a1, a2;
  } joint_item_t;

  typedef struct {
    longint f[8];
    logic   clip;
  } dyn_res_t;

  logic clk = 0, rst_n = 0;
  logic in_push = 0, out_pop = 0;
  logic in_full, out_empty;
  joint_item_t in_cur = '0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic signed [31:0] cfg_data = '0;
  logic signed [31:0] o_f [8];
  logic out_saturated;

  joint_item_t pending[$];
  dyn_res_t    awaited[$];
  longint      gains[8];
  longint      cycle_cnt = 0;
  int          errors = 0;
  int          push_gap = 0, pop_gap = 0, long_hold = 0;
  bit          calm = 0, long_done = 0, hold_start = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  rrr_arm_inverse_dynamics i_dut (
    .clk, .rst_n, .in_push, .in_full,
    .in_angle_base(in_cur.q1), .in_angle_shoulder(in_cur.q2), .in_angle_elbow(in_cur.q3),
    .in_rate_base(in_cur.v0), .in_rate_shoulder(in_cur.v1), .in_rate_elbow(in_cur.v2),
    .in_accel_base(in_cur.a0), .in_accel_shoulder(in_cur.a1), .in_accel_elbow(in_cur.a2),
    .out_empty, .out_pop,
    .out_inertia_rate_0(o_f[0]), .out_inertia_rate_1(o_f[1]), .out_inertia_rate_2(o_f[2]),
    .out_accel_coriolis_0(o_f[3]), .out_accel_coriolis_1(o_f[4]),
    .out_accel_coriolis_2(o_f[5]),
    .out_gravity_load_1(o_f[6]), .out_gravity_load_2(o_f[7]),
    .out_saturated, .cfg_we, .cfg_index, .cfg_data
  );

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rmul(longint a, longint b, int s);
    return shr(a * b + (64'sd1 <<< (s - 1)), s);
  endfunction

  function automatic longint clip32(longint x, ref logic flag);
    if (x > 64'sd2147483647) begin
      flag = 1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      flag = 1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  task automatic trig(input longint ang, output longint sn, output longint cs);
    longint z, x, y, dx, dy;
    bit flip;
    z = ang * 262144;
    x = GAIN_X;
    y = 0;
    flip = 0;
    while (z > PI_Z) z -= TWO_PI_Z;
    while (z < -PI_Z) z += TWO_PI_Z;
    if (z > HALF_PI_Z) begin
      z = PI_Z - z;
      flip = 1;
    end else if (z < -HALF_PI_Z) begin
      z = -PI_Z - z;
      flip = 1;
    end
    for (int i = 0; i < N_STEPS; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
      end
    end
    if (flip) x = -x;
    sn = shr(y + 8192, 14);
    cs = shr(x + 8192, 14);
  endtask

  task automatic predict_dynamics(input joint_item_t it, output dyn_res_t r);
    longint s2, c2, s3, c3, s23, c23, m[3][3], v[3], a[3];
    longint c2c2, c23c23, c2c23, c2s2, c23s23, c2s23, c23s2, p, q, rr, acc_r, acc_c;
    logic fl;
    fl = 0;
    v = '{it.v0, it.v1, it.v2};
    a = '{it.a0, it.a1, it.a2};
    trig(it.q2, s2, c2);
    trig(it.q3, s3, c3);
    trig(longint'(it.q2) + longint'(it.q3), s23, c23);
    c2c2 = rmul(c2, c2, 16); c23c23 = rmul(c23, c23, 16); c2c23 = rmul(c2, c23, 16);
    c2s2 = rmul(c2, s2, 16); c23s23 = rmul(c23, s23, 16);
    c2s23 = rmul(c2, s23, 16); c23s2 = rmul(c23, s2, 16);
    m[0][0] = clip32(gains[REG_INERTIA_BASE] + rmul(gains[REG_LINK2_COS_GAIN], c2c2, 16)
                     + rmul(gains[REG_LINK3_COS_GAIN], c23c23, 16)
                     + 2 * rmul(gains[REG_COUPLING_GAIN], c2c23, 16), fl);
    m[0][1] = 0; m[0][2] = 0; m[1][0] = 0; m[2][0] = 0;
    m[1][1] = clip32(gains[REG_SHOULDER_CONST] + 2 * rmul(gains[REG_COUPLING_GAIN], c3, 16), fl);
    m[1][2] = clip32(gains[REG_ELBOW_CONST] + rmul(gains[REG_COUPLING_GAIN], c3, 16), fl);
    m[2][1] = m[1][2];
    m[2][2] = gains[REG_ELBOW_CONST];
    p = clip32(-(rmul(gains[REG_LINK2_COS_GAIN], c2s2, 16)
                 + rmul(gains[REG_LINK3_COS_GAIN], c23s23, 16)
                 + rmul(gains[REG_COUPLING_GAIN], c2s23 + c23s2, 16)), fl);
    q = clip32(-(rmul(gains[REG_LINK3_COS_GAIN], c23s23, 16)
                 + rmul(gains[REG_COUPLING_GAIN], c2s23, 16)), fl);
    rr = clip32(rmul(gains[REG_COUPLING_GAIN], s3, 16), fl);
    for (int j = 0; j < 3; j++) begin
      acc_r = 0;
      acc_c = 0;
      for (int i = 0; i < 3; i++) begin
        acc_r += rmul(m[j][i], v[i], 8);
        acc_c += rmul(m[j][i], a[i], 8);
      end
      if (j == 0)
        acc_c += 2 * rmul(p, v[0] * v[1], 16) + 2 * rmul(q, v[0] * v[2], 16);
      else if (j == 1)
        acc_c += -rmul(p, v[0] * v[0], 16) - 2 * rmul(rr, v[1] * v[2], 16)
                 - rmul(rr, v[2] * v[2], 16);
      else
        acc_c += -rmul(q, v[0] * v[0], 16) + rmul(rr, v[1] * v[1], 16);
      r.f[j] = clip32(acc_r, fl);
      r.f[3 + j] = clip32(acc_c, fl);
    end
    r.f[6] = clip32(-(rmul(gains[REG_GRAVITY_LINK2], c2, 16)
                      + rmul(gains[REG_GRAVITY_LINK3], c23, 16)), fl);
    r.f[7] = clip32(-rmul(gains[REG_GRAVITY_LINK3], c23, 16), fl);
    r.clip = fl;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_cnt);
  endtask

  // driver
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (in_push && !in_full) begin
      dyn_res_t r;
      predict_dynamics(in_cur, r);
      awaited.insert(awaited.size(), r);
    end
    if (!(in_push && in_full)) begin
      if (push_gap > 0) begin
        push_gap <= push_gap - 1;
        in_push <= 0;
      end else if (pending.size() > 0 && rst_n) begin
        in_cur <= pending.pop_front();
        in_push <= 1;
        if (!calm && $urandom_range(0, 9) == 0) push_gap <= $urandom_range(1, 15);
      end else begin
        in_push <= 0;
      end
    end
  end

  // long receiver stall
  always @(posedge clk) begin
    if (hold_start && !long_done) begin
      long_hold <= 300;
      long_done <= 1;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (out_pop && !out_empty) begin
      if (awaited.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        dyn_res_t w;
        w = awaited.pop_front();
        for (int k = 0; k < 8; k++)
          if (longint'(o_f[k]) != w.f[k]) report_mismatch($sformatf("field %0d", k), o_f[k], w.f[k]);
        if (out_saturated !== w.clip) report_mismatch("saturated", out_saturated, w.clip);
      end
    end
    if (long_hold > 0) begin
      out_pop <= 0;
    end else if (pop_gap > 0) begin
      pop_gap <= pop_gap - 1;
      out_pop <= 0;
    end else begin
      out_pop <= 1;
      if (!calm && $urandom_range(0, 9) == 0) pop_gap <= $urandom_range(1, 15);
    end
  end

  always @(posedge clk)
    if (cycle_cnt > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end

  function automatic logic signed [15:0] rnd16();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(signed'($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic joint_item_t rand_item();
    joint_item_t it;
    it = joint_item_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    if ($urandom_range(0, 1)) begin
      it.v0 = rnd16(); it.v1 = rnd16(); it.v2 = rnd16();
      it.a0 = rnd16(); it.a1 = rnd16(); it.a2 = rnd16();
      it.q2 = rnd16(); it.q3 = rnd16();
    end
    return it;
  endfunction

  task automatic write_gain(input reg_idx_t idx, input longint val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= 32'(val);
    gains[idx] = longint'(signed'(32'(val)));
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic load_gains(input int mode);
    longint v;
    for (int i = 0; i < 8; i++) begin
      case (mode)
        0: v = longint'($urandom_range(0, 32'h0003ffff)) - 64'sd131072;
        1: v = 64'sd2147483647;
        2: v = -64'sd2147483648;
        default: v = longint'(signed'($urandom));
      endcase
      write_gain(reg_idx_t'(i), v);
    end
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_push || awaited.size() > 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
  endtask

  initial begin
    joint_item_t it;
    for (int i = 0; i < 8; i++) gains[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    // directed: extremes and angle wrap, with small random gains
    load_gains(0);
    for (int i = 0; i < 20; i++) begin
      it = '0;
      case (i % 5)
        0: it = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                  16'sh7fff, 16'sh7fff, 16'sh7fff};
        1: it = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                  16'sh8000, 16'sh8000, 16'sh8000};
        2: begin it.q2 = 16'sd6434; it.q3 = -16'sd6434; it.v0 = 16'sd256; end
        3: begin it.q1 = 16'($urandom); it.q2 = 16'sd12868; it.q3 = 16'sd12868; end
        default: it = rand_item();
      endcase
      pending.insert(pending.size(), it);
    end
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      load_gains(ph % 4);
      for (int i = 0; i < 250; i++) pending.insert(pending.size(), rand_item());
      if (ph == 2) begin
        hold_start = 1;
        wait (in_full);
      end
      if (ph == 4) calm = 1;
      drain();
    end
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
